[rtl/msi_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package msi_pkg;

  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned TRIG_ITERS_DEF = 16;

  localparam int unsigned MUL_W = 34;

  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [31:0] RATE_SAT    = 32'hFFFF_FFFF;
  localparam logic [19:0] ONE_MILLION = 20'd1000000;

  localparam logic signed [35:0] Q30_ONE     = 36'sd1073741824;
  localparam logic signed [35:0] Q30_HALF    = 36'sd536870912;
  localparam logic signed [35:0] CORDIC_GAIN = 36'sd652032874;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_MOVE_LAST = 2'd1,
    OP_SET       = 2'd2,
    OP_MOVE_FROM = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PROF_FLAT = 2'd0,
    PROF_ATAN = 2'd1,
    PROF_COS  = 2'd2
  } prof_e;

  typedef enum logic [2:0] {
    REG_PROFILE = 3'd0,
    REG_RAD_MIN = 3'd1,
    REG_RAD_MAX = 3'd2,
    REG_HGT_MIN = 3'd3,
    REG_HGT_MAX = 3'd4,
    REG_RAIL    = 3'd5
  } reg_e;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] target_e;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] start_e;
    logic [30:0]        speed_req;
    logic [31:0]        now_us;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] pos_e;
    logic               done_res;
    logic               limit_hit;
  } out_word_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] r;
    case (idx)
      5'd0:  r = 30'h3243F6A8;
      5'd1:  r = 30'h1DAC6705;
      5'd2:  r = 30'h0FADBAFC;
      5'd3:  r = 30'h07F56EA6;
      5'd4:  r = 30'h03FEAB76;
      5'd5:  r = 30'h01FFD55B;
      5'd6:  r = 30'h00FFFAAA;
      5'd7:  r = 30'h007FFF55;
      5'd8:  r = 30'h003FFFEA;
      5'd9:  r = 30'h001FFFFD;
      5'd10: r = 30'h000FFFFF;
      5'd11: r = 30'h0007FFFF;
      5'd12: r = 30'h0003FFFF;
      5'd13: r = 30'h0001FFFF;
      5'd14: r = 30'h0000FFFF;
      5'd15: r = 30'h00007FFF;
      5'd16: r = 30'h00003FFF;
      5'd17: r = 30'h00001FFF;
      5'd18: r = 30'h00000FFF;
      5'd19: r = 30'h000007FF;
      5'd20: r = 30'h000003FF;
      5'd21: r = 30'h000001FF;
      5'd22: r = 30'h000000FF;
      5'd23: r = 30'h0000007F;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/motion_segment_interpolator.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake              Word
// in        in   in_valid_i/in_stall_o   in_word_i  (in_word_t)
// out       out  out_valid_o/out_stall_i out_word_o (out_word_t)
// cfg       in   psel/penable/pwrite     paddr, pwdata, prdata (32 bit)
//
// One word at a time; every input word gives one output word.
// Set, and tick when done, go straight from decode to output. A move runs three
// serial squares, a 34-step root and a 64-step divide, with a second root for
// automatic speed. A running tick runs eleven serial products and the 64-step divide
// by one million, with the CORDIC steps as well under a CORDIC profile.
// Reset clears the move state and the registers to their defaults.
// A stalled output word holds; a new word is taken while it waits.

module motion_segment_interpolator
  import msi_pkg::*;
#(
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  parameter int unsigned TRIG_ITERS = TRIG_ITERS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_word_t    in_word_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_word_t        out_word_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [33:0] FIVE   = 34'(5) << FRAC_BITS;
  localparam logic [63:0] PH_CAP = 64'(2) << FRAC_BITS;
  localparam int unsigned PH_SH  = 30 - FRAC_BITS;
  localparam int unsigned ITERS  = (TRIG_ITERS > 24) ? 24 : TRIG_ITERS;
  localparam logic [6:0]  CORD_LAST = 7'(ITERS - 1);
  localparam logic [6:0]  MUL_LAST  = 7'(MUL_W - 1);
  localparam logic [6:0]  DIV_LAST  = 7'd63;
  localparam logic [6:0]  SQRT_LAST = 7'd33;

  typedef enum logic [22:0] {
    S_IDLE    = 23'd1 << 0,
    S_DECODE  = 23'd1 << 1,
    S_MV_INIT = 23'd1 << 2,
    S_MV_SQ   = 23'd1 << 3,
    S_MV_ACC  = 23'd1 << 4,
    S_MV_LEN  = 23'd1 << 5,
    S_MV_AUTO = 23'd1 << 6,
    S_MV_RATE = 23'd1 << 7,
    S_MV_RQ   = 23'd1 << 8,
    S_TK_PH   = 23'd1 << 9,
    S_TK_W    = 23'd1 << 10,
    S_TK_ANG  = 23'd1 << 11,
    S_TK_P    = 23'd1 << 12,
    S_TK_POS  = 23'd1 << 13,
    S_TK_NP   = 23'd1 << 14,
    S_TK_SQ   = 23'd1 << 15,
    S_TK_SS   = 23'd1 << 16,
    S_TK_CHK  = 23'd1 << 17,
    S_MUL     = 23'd1 << 18,
    S_DIV     = 23'd1 << 19,
    S_SQRT    = 23'd1 << 20,
    S_CORD    = 23'd1 << 21,
    S_DONE    = 23'd1 << 22
  } state_e;

  function automatic logic [32:0] abs33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic [35:0] abs36(input logic signed [35:0] v);
    return v[35] ? 36'(-v) : 36'(v);
  endfunction

  state_e state_q, state_d, ret_q, ret_d;

  logic [1:0]         prof_q;
  logic [30:0]        rmin_q, rmax_q;
  logic signed [31:0] hmin_q, hmax_q, rail_q;

  logic signed [31:0] sst_q [4];
  logic signed [31:0] sst_d [4];
  logic signed [32:0] sdl_q [4];
  logic signed [32:0] sdl_d [4];
  logic signed [31:0] cur_q [4];
  logic signed [31:0] cur_d [4];
  logic signed [31:0] np_q  [4];
  logic signed [31:0] np_d  [4];
  logic [31:0]        rate_q, rate_d, mst_q, mst_d;
  logic               fin_q, fin_d, lim_q, lim_d;

  in_word_t  item_q, item_d;
  out_word_t out_q, out_d;
  logic      out_valid_q, out_valid_d;

  logic [67:0]        mp_q, mp_d;
  logic [33:0]        ma_q, ma_d;
  logic [63:0]        dd_q, dd_d;
  logic [33:0]        rem_q, rem_d, dv_q, dv_d;
  logic [67:0]        rad_q, rad_d;
  logic [37:0]        sr_q, sr_d;
  logic [33:0]        sq_q, sq_d;
  logic signed [35:0] cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic               cmode_q, cmode_d;
  logic [6:0]         cnt_q, cnt_d;
  logic [2:0]         k_q, k_d;
  logic [65:0]        ssum_q, ssum_d;
  logic [33:0]        len_q, len_d, v_q, v_d;
  logic [31:0]        ph30_q, ph30_d;
  logic signed [35:0] p_q, p_d;
  logic [61:0]        rmax2_q, rmax2_d, rmin2_q, rmin2_d;

  logic signed [31:0] tg [4];
  logic signed [31:0] sg [4];

  logic [34:0]        mul_sum;
  logic [34:0]        div_t;
  logic               div_ge;
  logic [34:0]        div_r;
  logic [37:0]        sqr_r, sqr_t;
  logic               sqr_ge;
  logic signed [35:0] xs, ys, tab;
  logic               cup;

  logic signed [31:0] st_c;
  logic [33:0]        len_c, v_c;
  logic [32:0]        a33;
  logic [31:0]        a32;
  logic [63:0]        cap_c;
  logic signed [35:0] w_c, half_c, pc_c;
  logic               ge1_c, neg_c, ok_c;
  logic signed [63:0] prod_s, sp_c, sh_c;
  logic signed [35:0] sum_c;

  assign tg[0] = item_q.target_x;
  assign tg[1] = item_q.target_y;
  assign tg[2] = item_q.target_z;
  assign tg[3] = item_q.target_e;
  assign sg[0] = item_q.start_x;
  assign sg[1] = item_q.start_y;
  assign sg[2] = item_q.start_z;
  assign sg[3] = item_q.start_e;

  assign mul_sum = {1'b0, mp_q[67:34]} + {1'b0, (mp_q[0] ? ma_q : 34'd0)};
  assign div_t   = {rem_q, dd_q[63]};
  assign div_ge  = div_t >= {1'b0, dv_q};
  assign div_r   = div_ge ? div_t - {1'b0, dv_q} : div_t;
  assign sqr_r   = {sr_q[35:0], rad_q[67:66]};
  assign sqr_t   = {2'b00, sq_q, 2'b01};
  assign sqr_ge  = sqr_r >= sqr_t;
  assign xs      = cx_q >>> cnt_q[4:0];
  assign ys      = cy_q >>> cnt_q[4:0];
  assign tab     = 36'(atan_q30(cnt_q[4:0]));
  assign cup     = cmode_q ? cz_q[35] : !cy_q[35];

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign pready      = 1'b1;

  always_comb begin
    unique case (reg_e'(paddr[4:2]))
      REG_PROFILE: prdata = {30'd0, prof_q};
      REG_RAD_MIN: prdata = {1'b0, rmin_q};
      REG_RAD_MAX: prdata = {1'b0, rmax_q};
      REG_HGT_MIN: prdata = hmin_q;
      REG_HGT_MAX: prdata = hmax_q;
      REG_RAIL:    prdata = rail_q;
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prof_q <= '0;
      rmin_q <= '0;
      rmax_q <= 31'h7FFF_FFFF;
      hmin_q <= 32'sh8000_0000;
      hmax_q <= 32'sh7FFF_FFFF;
      rail_q <= 32'sh7FFF_FFFF;
    end else if (psel && penable && pwrite) begin
      unique case (reg_e'(paddr[4:2]))
        REG_PROFILE: prof_q <= pwdata[1:0];
        REG_RAD_MIN: rmin_q <= pwdata[30:0];
        REG_RAD_MAX: rmax_q <= pwdata[30:0];
        REG_HGT_MIN: hmin_q <= pwdata;
        REG_HGT_MAX: hmax_q <= pwdata;
        REG_RAIL:    rail_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    sst_d       = sst_q;
    sdl_d       = sdl_q;
    cur_d       = cur_q;
    np_d        = np_q;
    rate_d      = rate_q;
    mst_d       = mst_q;
    fin_d       = fin_q;
    lim_d       = lim_q;
    item_d      = item_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mp_d        = mp_q;
    ma_d        = ma_q;
    dd_d        = dd_q;
    rem_d       = rem_q;
    dv_d        = dv_q;
    rad_d       = rad_q;
    sr_d        = sr_q;
    sq_d        = sq_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    cz_d        = cz_q;
    cmode_d     = cmode_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    ssum_d      = ssum_q;
    len_d       = len_q;
    v_d         = v_q;
    ph30_d      = ph30_q;
    p_d         = p_q;
    rmax2_d     = rmax2_q;
    rmin2_d     = rmin2_q;

    st_c   = '0;
    len_c  = '0;
    v_c    = '0;
    a33    = '0;
    a32    = '0;
    cap_c  = '0;
    w_c    = '0;
    half_c = '0;
    pc_c   = '0;
    ge1_c  = 1'b0;
    neg_c  = 1'b0;
    ok_c   = 1'b0;
    prod_s = '0;
    sp_c   = '0;
    sh_c   = '0;
    sum_c  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_word_i;
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        lim_d = 1'b0;
        unique case (op_e'(item_q.op))
          OP_TICK: begin
            if (fin_q) begin
              state_d = S_DONE;
            end else if (rate_q == RATE_SAT) begin
              p_d     = Q30_ONE;
              fin_d   = 1'b1;
              k_d     = '0;
              state_d = S_TK_POS;
            end else begin
              ma_d    = {2'b00, item_q.now_us - mst_q};
              mp_d    = {34'd0, 34'(rate_q)};
              cnt_d   = '0;
              ret_d   = S_TK_PH;
              state_d = S_MUL;
            end
          end
          OP_SET: begin
            for (int k = 0; k < 4; k++) begin
              sst_d[k] = tg[k];
              sdl_d[k] = '0;
            end
            state_d = S_DONE;
          end
          default: state_d = S_MV_INIT;
        endcase
      end

      S_MV_INIT: begin
        for (int k = 0; k < 4; k++) begin
          st_c     = (item_q.op == OP_MOVE_LAST) ? sst_q[k] + sdl_q[k][31:0] : sg[k];
          sst_d[k] = st_c;
          sdl_d[k] = 33'(tg[k]) - 33'(st_c);
        end
        fin_d   = 1'b0;
        mst_d   = item_q.now_us;
        ssum_d  = '0;
        k_d     = '0;
        state_d = S_MV_SQ;
      end

      S_MV_SQ: begin
        a33     = abs33(sdl_q[k_q[1:0]]);
        ma_d    = 34'(a33);
        mp_d    = {34'd0, 34'(a33)};
        cnt_d   = '0;
        ret_d   = S_MV_ACC;
        state_d = S_MUL;
      end

      S_MV_ACC: begin
        ssum_d = ssum_q + mp_q[65:0];
        k_d    = k_q + 3'd1;
        if (k_q == 3'd2) begin
          rad_d   = 68'(ssum_d);
          sr_d    = '0;
          sq_d    = '0;
          cnt_d   = '0;
          ret_d   = S_MV_LEN;
          state_d = S_SQRT;
        end else begin
          state_d = S_MV_SQ;
        end
      end

      S_MV_LEN: begin
        a33   = abs33(sdl_q[3]);
        len_c = (sq_q < 34'(a33)) ? 34'(a33) : sq_q;
        len_d = len_c;
        if (34'(item_q.speed_req) < FIVE) begin
          rad_d   = 68'(len_c) << FRAC_BITS;
          sr_d    = '0;
          sq_d    = '0;
          cnt_d   = '0;
          ret_d   = S_MV_AUTO;
          state_d = S_SQRT;
        end else begin
          v_d     = 34'(item_q.speed_req);
          state_d = S_MV_RATE;
        end
      end

      S_MV_AUTO: begin
        v_c     = (sq_q << 3) + (sq_q << 1);
        v_d     = (v_c < FIVE) ? FIVE : v_c;
        state_d = S_MV_RATE;
      end

      S_MV_RATE: begin
        if (len_q == '0) begin
          rate_d  = RATE_SAT;
          state_d = S_DONE;
        end else begin
          dd_d    = 64'(v_q) << FRAC_BITS;
          dv_d    = len_q;
          rem_d   = '0;
          cnt_d   = '0;
          ret_d   = S_MV_RQ;
          state_d = S_DIV;
        end
      end

      S_MV_RQ: begin
        rate_d  = (dd_q[63:32] != '0) ? RATE_SAT : dd_q[31:0];
        state_d = S_DONE;
      end

      S_TK_PH: begin
        dd_d    = mp_q[63:0];
        dv_d    = 34'(ONE_MILLION);
        rem_d   = '0;
        cnt_d   = '0;
        ret_d   = S_TK_W;
        state_d = S_DIV;
      end

      S_TK_W: begin
        cap_c   = (dd_q > PH_CAP) ? PH_CAP : dd_q;
        ph30_d  = 32'(cap_c << PH_SH);
        ma_d    = 34'(ph30_d);
        mp_d    = {34'd0, 34'(PI_Q30)};
        cnt_d   = '0;
        ret_d   = S_TK_ANG;
        state_d = S_MUL;
      end

      S_TK_ANG: begin
        w_c   = 36'(mp_q[63:30]) - 36'(HALF_PI_Q30);
        ge1_c = ph30_q[31] | ph30_q[30];
        cnt_d = '0;
        k_d   = '0;
        unique case (prof_e'(prof_q))
          PROF_ATAN: begin
            cx_d    = Q30_ONE;
            cy_d    = w_c;
            cz_d    = '0;
            cmode_d = 1'b0;
            state_d = S_CORD;
          end
          PROF_COS: begin
            if (ge1_c) begin
              p_d     = Q30_ONE;
              fin_d   = 1'b1;
              state_d = S_TK_POS;
            end else begin
              cx_d    = CORDIC_GAIN;
              cy_d    = '0;
              cz_d    = w_c;
              cmode_d = 1'b1;
              state_d = S_CORD;
            end
          end
          default: begin
            if (ge1_c) begin
              p_d   = Q30_ONE;
              fin_d = 1'b1;
            end else begin
              p_d = 36'(ph30_q);
            end
            state_d = S_TK_POS;
          end
        endcase
      end

      S_TK_P: begin
        half_c = cmode_q ? (cy_q >>> 1) : (cz_q >>> 1);
        pc_c   = Q30_HALF + half_c;
        if (cmode_q) begin
          p_d = (pc_c > Q30_ONE) ? Q30_ONE : pc_c;
        end else if (pc_c >= Q30_ONE) begin
          p_d   = Q30_ONE;
          fin_d = 1'b1;
        end else begin
          p_d = pc_c;
        end
        k_d     = '0;
        state_d = S_TK_POS;
      end

      S_TK_POS: begin
        a33     = abs33(sdl_q[k_q[1:0]]);
        ma_d    = 34'(abs36(p_q));
        mp_d    = {34'd0, 34'(a33)};
        cnt_d   = '0;
        ret_d   = S_TK_NP;
        state_d = S_MUL;
      end

      S_TK_NP: begin
        neg_c  = p_q[35] ^ sdl_q[k_q[1:0]][32];
        prod_s = mp_q[63:0];
        sp_c   = neg_c ? -prod_s : prod_s;
        sh_c   = sp_c >>> 30;
        sum_c  = 36'(sst_q[k_q[1:0]]) + sh_c[35:0];
        if (sum_c > 36'sd2147483647) begin
          np_d[k_q[1:0]] = 32'sh7FFF_FFFF;
        end else if (sum_c < -36'sd2147483648) begin
          np_d[k_q[1:0]] = 32'sh8000_0000;
        end else begin
          np_d[k_q[1:0]] = sum_c[31:0];
        end
        if (k_q == 3'd3) begin
          k_d     = '0;
          ssum_d  = '0;
          state_d = S_TK_SQ;
        end else begin
          k_d     = k_q + 3'd1;
          state_d = S_TK_POS;
        end
      end

      S_TK_SQ: begin
        case (k_q)
          3'd3:    a32 = {1'b0, rmax_q};
          3'd4:    a32 = {1'b0, rmin_q};
          default: a32 = abs32(np_q[k_q[1:0]]);
        endcase
        ma_d    = 34'(a32);
        mp_d    = {34'd0, 34'(a32)};
        cnt_d   = '0;
        ret_d   = S_TK_SS;
        state_d = S_MUL;
      end

      S_TK_SS: begin
        case (k_q)
          3'd3:    rmax2_d = mp_q[61:0];
          3'd4:    rmin2_d = mp_q[61:0];
          default: ssum_d  = ssum_q + mp_q[65:0];
        endcase
        k_d     = k_q + 3'd1;
        state_d = (k_q == 3'd4) ? S_TK_CHK : S_TK_SQ;
      end

      S_TK_CHK: begin
        ok_c = (ssum_q <= 66'(rmax2_q)) && (ssum_q >= 66'(rmin2_q)) &&
               (np_q[2] >= hmin_q) && (np_q[2] <= hmax_q) && (np_q[3] <= rail_q);
        if (ok_c) begin
          cur_d = np_q;
        end else begin
          fin_d = 1'b1;
          lim_d = 1'b1;
          for (int k = 0; k < 4; k++) begin
            sst_d[k] = cur_q[k];
            sdl_d[k] = '0;
          end
        end
        state_d = S_DONE;
      end

      S_MUL: begin
        mp_d  = {mul_sum, mp_q[33:1]};
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == MUL_LAST) begin
          state_d = ret_q;
        end
      end

      S_DIV: begin
        dd_d  = {dd_q[62:0], div_ge};
        rem_d = div_r[33:0];
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == DIV_LAST) begin
          state_d = ret_q;
        end
      end

      S_SQRT: begin
        rad_d = rad_q << 2;
        sr_d  = sqr_ge ? sqr_r - sqr_t : sqr_r;
        sq_d  = {sq_q[32:0], sqr_ge};
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == SQRT_LAST) begin
          state_d = ret_q;
        end
      end

      S_CORD: begin
        if (cup) begin
          cx_d = cx_q + ys;
          cy_d = cy_q - xs;
          cz_d = cz_q + tab;
        end else begin
          cx_d = cx_q - ys;
          cy_d = cy_q + xs;
          cz_d = cz_q - tab;
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == CORD_LAST) begin
          state_d = S_TK_P;
        end
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d     = 1'b1;
          out_d.pos_x     = cur_q[0];
          out_d.pos_y     = cur_q[1];
          out_d.pos_z     = cur_q[2];
          out_d.pos_e     = cur_q[3];
          out_d.done_res  = fin_q;
          out_d.limit_hit = lim_q;
          state_d         = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      fin_q       <= 1'b1;
      rate_q      <= '0;
      mst_q       <= '0;
      for (int k = 0; k < 4; k++) begin
        sst_q[k] <= '0;
        sdl_q[k] <= '0;
        cur_q[k] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      fin_q       <= fin_d;
      rate_q      <= rate_d;
      mst_q       <= mst_d;
      sst_q       <= sst_d;
      sdl_q       <= sdl_d;
      cur_q       <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ret_q   <= ret_d;
    np_q    <= np_d;
    lim_q   <= lim_d;
    item_q  <= item_d;
    out_q   <= out_d;
    mp_q    <= mp_d;
    ma_q    <= ma_d;
    dd_q    <= dd_d;
    rem_q   <= rem_d;
    dv_q    <= dv_d;
    rad_q   <= rad_d;
    sr_q    <= sr_d;
    sq_q    <= sq_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    cz_q    <= cz_d;
    cmode_q <= cmode_d;
    cnt_q   <= cnt_d;
    k_q     <= k_d;
    ssum_q  <= ssum_d;
    len_q   <= len_d;
    v_q     <= v_d;
    ph30_q  <= ph30_d;
    p_q     <= p_d;
    rmax2_q <= rmax2_d;
    rmin2_q <= rmin2_d;
  end

endmodule

`default_nettype wire

[tb/tb_motion_segment_interpolator.sv]
`timescale 1ns / 1ps

module tb_motion_segment_interpolator;
  import msi_pkg::*;

  localparam int unsigned FRAC = 16;
  localparam int unsigned ITERS = 16;
  localparam longint MILLION = 1000000;
  localparam longint unsigned SAT_RATE = 64'hFFFF_FFFF;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint HALF_Q30 = 64'sd536870912;
  localparam longint unsigned PI_30 = 64'd3373259426;
  localparam longint HALF_PI_30 = 64'sd1686629713;
  localparam longint GAIN_30 = 64'sd652032874;
  localparam longint ATAN_ANGLE [16] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF
  };

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_word_t out_word_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  motion_segment_interpolator dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i,
    .out_valid_o, .out_stall_i, .out_word_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #36ms;
    $display("tb: failure");
    $finish;
  end

  // axis state of the interpolator as predicted
  longint seg_start [4];
  longint seg_delta [4];
  longint cur_pos [4];
  longint unsigned time_rate, move_t0;
  bit move_done;
  bit [1:0] profile;
  longint unsigned rad_lo, rad_hi;
  longint z_lo, z_hi, e_hi;

  out_word_t pos_q [$];
  int errors = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int stall_left = 0;
  out_word_t want;
  row_t rows [$];

  function automatic longint unsigned root68(bit [67:0] v);
    bit [69:0] r, q, trial;
    r = '0;
    q = '0;
    for (int i = 33; i >= 0; i--) begin
      r = (r << 2) | v[2*i +: 2];
      trial = (q << 2) | 1;
      if (r >= trial) begin
        r = r - trial;
        q = (q << 1) | 1;
      end else begin
        q = q << 1;
      end
    end
    return q[63:0];
  endfunction

  function automatic longint atan_q30(longint w);
    longint x, y, z, xs, ys;
    x = ONE_Q30;
    y = w;
    z = 0;
    for (int i = 0; i < ITERS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += ATAN_ANGLE[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_ANGLE[i];
      end
    end
    return z;
  endfunction

  function automatic longint sin_q30(longint a);
    longint x, y, z, xs, ys;
    x = GAIN_30;
    y = 0;
    z = a;
    for (int i = 0; i < ITERS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= ATAN_ANGLE[i];
      end else begin
        x += ys; y -= xs; z += ATAN_ANGLE[i];
      end
    end
    return y;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void plan_move(longint st [4], longint tg [4], longint unsigned spd,
                                   longint unsigned now);
    longint d [4];
    bit [67:0] acc;
    bit [65:0] m;
    longint unsigned len, ae, v, q;
    longint unsigned five;
    five = 64'd5 << FRAC;
    acc = '0;
    for (int k = 0; k < 4; k++) d[k] = tg[k] - st[k];
    for (int k = 0; k < 3; k++) begin
      m = d[k] < 0 ? -d[k] : d[k];
      acc += m * m;
    end
    len = root68(acc);
    ae = d[3] < 0 ? -d[3] : d[3];
    if (len < ae) len = ae;
    v = spd;
    if (v < five) v = 10 * root68(len << FRAC);
    if (v < five) v = five;
    if (len == 0) begin
      time_rate = SAT_RATE;
    end else begin
      q = (v << FRAC) / len;
      time_rate = q > SAT_RATE ? SAT_RATE : q;
    end
    for (int k = 0; k < 4; k++) begin
      seg_start[k] = st[k];
      seg_delta[k] = d[k];
    end
    move_done = 1'b0;
    move_t0 = now;
  endfunction

  function automatic bit advance_tick(longint unsigned now);
    longint p, w;
    longint np [4];
    longint unsigned el, phase, ph30;
    bit [63:0] sq;
    if (move_done) return 1'b0;
    if (time_rate >= SAT_RATE) begin
      p = ONE_Q30;
      move_done = 1'b1;
    end else begin
      el = (now - move_t0) & 64'hFFFF_FFFF;
      phase = el * time_rate / MILLION;
      if (phase > (64'd2 << FRAC)) phase = 64'd2 << FRAC;
      ph30 = phase << (30 - FRAC);
      w = longint'((PI_30 * ph30) >> 30) - HALF_PI_30;
      if (profile == PROF_ATAN) begin
        p = HALF_Q30 + (atan_q30(w) >>> 1);
        if (p >= ONE_Q30) begin
          p = ONE_Q30; move_done = 1'b1;
        end
      end else if (profile == PROF_COS) begin
        if (phase >= (64'd1 << FRAC)) begin
          p = ONE_Q30; move_done = 1'b1;
        end else begin
          p = HALF_Q30 + (sin_q30(w) >>> 1);
          if (p > ONE_Q30) p = ONE_Q30;
        end
      end else begin
        if (phase >= (64'd1 << FRAC)) begin
          p = ONE_Q30; move_done = 1'b1;
        end else begin
          p = longint'(ph30);
        end
      end
    end
    sq = '0;
    for (int k = 0; k < 4; k++) np[k] = clip32(seg_start[k] + ((p * seg_delta[k]) >>> 30));
    for (int k = 0; k < 3; k++) sq += np[k] * np[k];
    if (sq <= rad_hi * rad_hi && sq >= rad_lo * rad_lo && np[2] >= z_lo &&
        np[2] <= z_hi && np[3] <= e_hi) begin
      for (int k = 0; k < 4; k++) cur_pos[k] = np[k];
      return 1'b0;
    end
    move_done = 1'b1;
    for (int k = 0; k < 4; k++) begin
      seg_start[k] = cur_pos[k];
      seg_delta[k] = 0;
    end
    return 1'b1;
  endfunction

  function automatic out_word_t interpolate(in_word_t w);
    longint tg [4], st [4];
    longint sum;
    bit hit;
    out_word_t r;
    hit = 1'b0;
    tg = '{longint'(w.target_x), longint'(w.target_y), longint'(w.target_z),
           longint'(w.target_e)};
    st = '{longint'(w.start_x), longint'(w.start_y), longint'(w.start_z),
           longint'(w.start_e)};
    case (op_e'(w.op))
      OP_TICK: hit = advance_tick(w.now_us);
      OP_SET: begin
        for (int k = 0; k < 4; k++) begin
          seg_start[k] = tg[k];
          seg_delta[k] = 0;
        end
      end
      OP_MOVE_LAST: begin
        for (int k = 0; k < 4; k++) begin
          sum = seg_start[k] + seg_delta[k];
          st[k] = longint'($signed(sum[31:0]));
        end
        plan_move(st, tg, w.speed_req, w.now_us);
      end
      default: plan_move(st, tg, w.speed_req, w.now_us);
    endcase
    r.pos_x = cur_pos[0][31:0];
    r.pos_y = cur_pos[1][31:0];
    r.pos_z = cur_pos[2][31:0];
    r.pos_e = cur_pos[3][31:0];
    r.done_res = move_done;
    r.limit_hit = hit;
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (pos_q.size() == 0) begin
        $error("unexpected word %h", out_word_o);
        errors++;
      end else begin
        want = pos_q.pop_front();
        if (out_word_o.pos_x !== want.pos_x) begin
          $error("pos_x exp %h got %h", want.pos_x, out_word_o.pos_x); errors++;
        end
        if (out_word_o.pos_y !== want.pos_y) begin
          $error("pos_y exp %h got %h", want.pos_y, out_word_o.pos_y); errors++;
        end
        if (out_word_o.pos_z !== want.pos_z) begin
          $error("pos_z exp %h got %h", want.pos_z, out_word_o.pos_z); errors++;
        end
        if (out_word_o.pos_e !== want.pos_e) begin
          $error("pos_e exp %h got %h", want.pos_e, out_word_o.pos_e); errors++;
        end
        if (out_word_o.done_res !== want.done_res) begin
          $error("done_res exp %b got %b", want.done_res, out_word_o.done_res); errors++;
        end
        if (out_word_o.limit_hit !== want.limit_hit) begin
          $error("limit_hit exp %b got %b", want.limit_hit, out_word_o.limit_hit); errors++;
        end
      end
      stall_left = calm ? 0 : $urandom_range(0, 10);
    end
    if (hold_req) begin
      hold_left = 3000;
      hold_req = 1'b0;
    end
    out_stall_i <= (hold_left > 0) || (stall_left > 0);
    if (hold_left > 0) hold_left--;
    if (stall_left > 0) stall_left--;
  end

  task automatic send(in_word_t w, bit typed, out_word_t res);
    int gap;
    out_word_t p;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    p = interpolate(w);
    pos_q.push_back(typed ? res : p);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pos_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 5'(idx) << 2;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PROFILE: profile = val[1:0];
      REG_RAD_MIN: rad_lo = val[30:0];
      REG_RAD_MAX: rad_hi = val[30:0];
      REG_HGT_MIN: z_lo = longint'($signed(val));
      REG_HGT_MAX: z_hi = longint'($signed(val));
      default: e_hi = longint'($signed(val));
    endcase
  endtask

  function automatic in_word_t mk(op_e op, int tx, int ty, int tz, int te, int sx, int sy,
                                  int sz, int se, logic [30:0] spd, logic [31:0] now);
    in_word_t w;
    w.op = op;
    w.target_x = tx; w.target_y = ty; w.target_z = tz; w.target_e = te;
    w.start_x = sx; w.start_y = sy; w.start_z = sz; w.start_e = se;
    w.speed_req = spd;
    w.now_us = now;
    return w;
  endfunction

  function automatic int coord();
    return int'($urandom) >>> $urandom_range(6, 31);
  endfunction

  function automatic out_word_t pos_word(int v, bit done);
    out_word_t r;
    r.pos_x = v; r.pos_y = v; r.pos_z = v; r.pos_e = v;
    r.done_res = done;
    r.limit_hit = 1'b0;
    return r;
  endfunction

  localparam int MAXI = 32'h7FFF_FFFF;
  localparam int MINI = 32'h8000_0000;

  initial begin
    logic [351:0] rnd;
    in_word_t w;
    logic [31:0] now;
    int n_ticks;
    for (int k = 0; k < 4; k++) begin
      seg_start[k] = 0; seg_delta[k] = 0; cur_pos[k] = 0;
    end
    time_rate = 0;
    move_t0 = 0;
    move_done = 1'b1;
    profile = PROF_FLAT;
    rad_lo = 0;
    rad_hi = 64'h7FFF_FFFF;
    z_lo = -64'sd2147483648;
    z_hi = 64'sd2147483647;
    e_hi = 64'sd2147483647;

    rows = '{
      '{mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, pos_word(0, 1'b1)},
      '{mk(OP_MOVE_FROM, 1000, 1000, 1000, 1000, 1000, 1000, 1000, 1000, 0, 7), 1'b1,
        pos_word(0, 1'b0)},
      '{mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 9), 1'b1, pos_word(1000, 1'b1)},
      '{mk(OP_SET, MAXI, MINI, MAXI, MINI, 0, 0, 0, 0, 0, 0), 1'b1, pos_word(1000, 1'b1)},
      '{mk(OP_MOVE_LAST, MINI, MAXI, MINI, MAXI, 0, 0, 0, 0, 0, 0), 1'b0, '0},
      '{mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1'b0, '0},
      '{mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0010_0000), 1'b0, '0},
      '{mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF), 1'b0, '0},
      '{mk(OP_MOVE_FROM, MINI, MINI, MINI, MINI, MAXI, MAXI, MAXI, MAXI, 31'h7FFF_FFFF,
           32'hFFFF_FFF0), 1'b0, '0},
      '{mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 5), 1'b0, '0},
      '{mk(OP_MOVE_FROM, 6553600, -3276800, 65536, 0, 0, 0, 0, 0, 1, 100), 1'b0, '0},
      '{mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 40000), 1'b0, '0},
      '{mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 200000), 1'b0, '0},
      '{mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 2000000), 1'b0, '0},
      '{mk(OP_MOVE_LAST, 0, 0, 0, -655360, 0, 0, 0, 0, 31'h50000, 0), 1'b0, '0},
      '{mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 500000), 1'b0, '0},
      '{mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 5000000), 1'b0, '0},
      '{mk(OP_SET, 1, -1, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send(rows[i].w, rows[i].typed, rows[i].res);

    now = $urandom;
    for (int ph = 0; ph < 10; ph++) begin
      drain();
      calm = (ph % 3 == 0);
      write_reg(REG_PROFILE, ph % 4);
      case (ph)
        1: begin
          write_reg(REG_RAD_MIN, 0); write_reg(REG_RAD_MAX, 32'h7FFF_FFFF);
          write_reg(REG_HGT_MIN, MINI); write_reg(REG_HGT_MAX, MAXI);
          write_reg(REG_RAIL, MAXI);
        end
        2: begin
          write_reg(REG_RAD_MIN, 32'h7FFF_FFFF); write_reg(REG_RAD_MAX, 0);
          write_reg(REG_HGT_MIN, MAXI); write_reg(REG_HGT_MAX, MINI);
          write_reg(REG_RAIL, MINI);
        end
        default: begin
          write_reg(REG_RAD_MIN, $urandom_range(0, 1 << 22));
          write_reg(REG_RAD_MAX, $urandom_range(1 << 22, 1 << 28));
          write_reg(REG_HGT_MIN, -int'($urandom_range(0, 1 << 26)));
          write_reg(REG_HGT_MAX, $urandom_range(0, 1 << 26));
          write_reg(REG_RAIL, int'($urandom) >>> $urandom_range(2, 8));
        end
      endcase
      for (int it = 0; it < 68; ) begin
        if (ph == 3 && it == 10) hold_req = 1'b1;
        if (ph == 5 && it == 30) drain();
        if ($urandom_range(0, 9) == 0) begin
          rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom};
          w = rnd[$bits(in_word_t)-1:0];
          send(w, 1'b0, '0);
          it++;
        end else begin
          if ($urandom_range(0, 3) == 0) begin
            send(mk(OP_SET, coord(), coord(), coord(), coord(), 0, 0, 0, 0, 0, 0), 1'b0, '0);
            it++;
          end
          w = mk($urandom_range(0, 1) ? OP_MOVE_LAST : OP_MOVE_FROM, coord(), coord(),
                 coord(), coord(), coord(), coord(), coord(), coord(),
                 $urandom_range(0, 3) == 0 ? 31'($urandom_range(0, 5 << 16))
                                           : 31'($urandom) >> $urandom_range(0, 30), now);
          send(w, 1'b0, '0);
          n_ticks = $urandom_range(2, 10);
          for (int t = 0; t < n_ticks; t++) begin
            now += $urandom_range(0, 1 << $urandom_range(4, 24));
            send(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, now), 1'b0, '0);
          end
          it += n_ticks + 1;
        end
      end
    end

    drain();
    repeat (400) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/msi_pkg.sv
rtl/motion_segment_interpolator.sv
tb/tb_motion_segment_interpolator.sv
